FILE: hdl/matrix_inverse_4x4_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix inverse
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define MI4_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a condition never holds
`define MI4_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/mi4_pkg.sv
// ----------------------------------------------------------------------------
// mi4_pkg
// Types, constants and the operation decoder of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package mi4_pkg;

  localparam int ELEM_W    = 32;
  localparam int NCHUNK    = 4;
  localparam int BOP_W     = NCHUNK * ELEM_W;
  localparam int ACC_W     = 136;
  localparam int SCR_DEPTH = 29;

  localparam logic [4:0] HI_MINOR_BASE = 5'd6;
  localparam logic [4:0] ADJ_BASE      = 5'd12;
  localparam logic [4:0] DET_IDX       = 5'd28;

  localparam logic [ELEM_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_MINOR,
    PH_ADJ,
    PH_DET,
    PH_DIV
  } phase_e;

  typedef struct packed {
    logic [3:0]               element_index;
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               result_index;
    logic signed [ELEM_W-1:0] result_value;
    logic                     singular;
    logic                     saturated;
    logic                     last_result;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] a_idx;
    logic       b_is_scr;
    logic [4:0] b_idx;
    logic       neg;
    logic       first;
    logic       last;
    logic [4:0] wr_idx;
    logic [1:0] chunk;
  } mac_cmd_t;

  typedef struct packed {
    logic       start;
    logic [3:0] idx;
  } div_req_t;

  function automatic logic [3:0] pair_cols(logic [2:0] p);
    logic [3:0] c;
    case (p)
      3'd0:    c = {2'd0, 2'd1};
      3'd1:    c = {2'd0, 2'd2};
      3'd2:    c = {2'd0, 2'd3};
      3'd3:    c = {2'd1, 2'd2};
      3'd4:    c = {2'd1, 2'd3};
      3'd5:    c = {2'd2, 2'd3};
      default: c = {2'd0, 2'd1};
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pair_code(logic [1:0] x0, logic [1:0] x1);
    logic [2:0] p;
    case ({x0, x1})
      {2'd0, 2'd1}: p = 3'd0;
      {2'd0, 2'd2}: p = 3'd1;
      {2'd0, 2'd3}: p = 3'd2;
      {2'd1, 2'd2}: p = 3'd3;
      {2'd1, 2'd3}: p = 3'd4;
      {2'd2, 2'd3}: p = 3'd5;
      default:      p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic mac_cmd_t op_decode(phase_e ph, logic [3:0] grp, logic [1:0] term);
    mac_cmd_t   c;
    logic       hi;
    logic [2:0] p;
    logic [1:0] ca, cb, r0, r1, i, j, r, cq, x0, x1, kk;
    logic       found;
    logic [4:0] base;
    c = '0;
    hi = (grp >= 4'd6);
    p = hi ? 3'(grp - 4'd6) : grp[2:0];
    {ca, cb} = pair_cols(p);
    r0 = hi ? 2'd2 : 2'd0;
    r1 = r0 + 2'd1;
    i = grp[3:2];
    j = grp[1:0];
    r = {j[1], ~j[0]};
    cq = (term < i) ? term : term + 2'd1;
    x0 = 2'd0;
    x1 = 2'd0;
    found = 1'b0;
    for (int k = 0; k < 4; k++) begin
      kk = 2'(k);
      if (kk != i && kk != cq) begin
        if (!found) x0 = kk;
        else x1 = kk;
        found = 1'b1;
      end
    end
    base = j[1] ? 5'd0 : HI_MINOR_BASE;
    unique case (ph)
      PH_MINOR: begin
        c.first  = (term == 2'd0);
        c.last   = (term == 2'd1);
        c.wr_idx = {1'b0, grp};
        if (term[0]) begin
          c.a_idx = {r0, cb};
          c.b_idx = {1'b0, r1, ca};
          c.neg   = 1'b1;
        end else begin
          c.a_idx = {r0, ca};
          c.b_idx = {1'b0, r1, cb};
        end
      end
      PH_ADJ: begin
        c.a_idx    = {r, cq};
        c.b_is_scr = 1'b1;
        c.b_idx    = base + {2'b00, pair_code(x0, x1)};
        c.neg      = term[0] ^ i[0] ^ j[0];
        c.first    = (term == 2'd0);
        c.last     = (term == 2'd2);
        c.wr_idx   = ADJ_BASE + {1'b0, grp};
      end
      PH_DET: begin
        c.a_idx    = {2'b00, term};
        c.b_is_scr = 1'b1;
        c.b_idx    = ADJ_BASE + {1'b0, term, 2'b00};
        c.first    = (term == 2'd0);
        c.last     = (term == 2'd3);
        c.wr_idx   = DET_IDX;
      end
      PH_DIV: begin
        c.b_is_scr = 1'b1;
        c.b_idx    = ADJ_BASE + {1'b0, grp};
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/mi4_ctrl.sv
// ----------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: steps minors, cofactors, determinant and the per-element divides.
// ----------------------------------------------------------------------------
module mi4_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               launch_i,
  input  logic               div_done_i,
  output logic               busy_o,
  output mi4_pkg::mac_cmd_t  cmd_o,
  output mi4_pkg::div_req_t  div_req_o
);
  import mi4_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_RD,
    ST_DIV_LD,
    ST_DIV_WAIT
  } state_e;

  localparam logic [1:0] CHUNK_LAST = 2'(NCHUNK - 1);
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_e     state_q;
  phase_e     phase_q;
  logic [3:0] grp_q;
  logic [1:0] term_q, chunk_q, drain_q;
  logic [1:0] term_last;
  logic [3:0] grp_last;

  always_comb begin
    unique case (phase_q)
      PH_MINOR: begin term_last = 2'd1; grp_last = 4'd11; end
      PH_ADJ:   begin term_last = 2'd2; grp_last = 4'd15; end
      PH_DET:   begin term_last = 2'd3; grp_last = 4'd0;  end
      PH_DIV:   begin term_last = 2'd0; grp_last = 4'd15; end
    endcase
  end

  always_comb begin
    cmd_o       = op_decode(phase_q, grp_q, term_q);
    cmd_o.valid = (state_q == ST_MAC);
    cmd_o.chunk = chunk_q;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign div_req_o.start = (state_q == ST_DIV_LD);
  assign div_req_o.idx   = grp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MINOR;
      grp_q   <= '0;
      term_q  <= '0;
      chunk_q <= '0;
      drain_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (launch_i) begin
            state_q <= ST_MAC;
            phase_q <= PH_MINOR;
            grp_q   <= '0;
            term_q  <= '0;
            chunk_q <= '0;
          end
        end
        ST_MAC: begin
          chunk_q <= chunk_q + 2'd1;
          if (chunk_q == CHUNK_LAST) begin
            if (term_q == term_last) begin
              term_q <= '0;
              if (grp_q == grp_last) begin
                grp_q   <= '0;
                drain_q <= '0;
                state_q <= ST_DRAIN;
              end else begin
                grp_q <= grp_q + 4'd1;
              end
            end else begin
              term_q <= term_q + 2'd1;
            end
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q + 2'd1;
          if (drain_q == DRAIN_LAST) begin
            unique case (phase_q)
              PH_MINOR: begin phase_q <= PH_ADJ; state_q <= ST_MAC; end
              PH_ADJ:   begin phase_q <= PH_DET; state_q <= ST_MAC; end
              PH_DET, PH_DIV: begin phase_q <= PH_DIV; state_q <= ST_DIV_RD; end
            endcase
          end
        end
        ST_DIV_RD: state_q <= ST_DIV_LD;
        ST_DIV_LD: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done_i) begin
            if (grp_q == grp_last) begin
              state_q <= ST_IDLE;
              grp_q   <= '0;
            end else begin
              grp_q   <= grp_q + 4'd1;
              state_q <= ST_DIV_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/mi4_mac.sv
// ----------------------------------------------------------------------------
// mi4_mac
// Element store, scratch file and a chunked 32-bit multiply-accumulate.
// ----------------------------------------------------------------------------
module mi4_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [3:0]                       wr_idx_i,
  input  logic [mi4_pkg::ELEM_W-1:0]       wr_data_i,
  input  mi4_pkg::mac_cmd_t                cmd_i,
  output logic signed [mi4_pkg::ACC_W-1:0] scr_rd_o,
  output logic signed [mi4_pkg::ACC_W-1:0] det_o
);
  import mi4_pkg::*;

  logic [ELEM_W-1:0]        mem_q [16];
  logic [ACC_W-1:0]         scr_q [SCR_DEPTH];
  logic signed [ELEM_W-1:0] a_q, be_q;
  logic [ACC_W-1:0]         bs_q;
  mac_cmd_t                 s1_q, s2_q;
  logic [BOP_W-1:0]         bop;
  logic [ELEM_W-1:0]        chunk;
  logic signed [ELEM_W:0]   bext;
  logic signed [2*ELEM_W:0] pp_d, pp_q;
  logic [ACC_W-1:0]         ppx, sh, acc_q, acc_d, acc_base;
  logic                     wr_scr;

  always_comb begin
    bop   = s1_q.b_is_scr ? bs_q[BOP_W-1:0] : BOP_W'(be_q);
    chunk = bop[{s1_q.chunk, 5'b0} +: ELEM_W];
    bext  = (s1_q.chunk == 2'(NCHUNK - 1)) ? {chunk[ELEM_W-1], chunk} : {1'b0, chunk};
    pp_d  = a_q * bext;
  end

  always_comb begin
    ppx      = ACC_W'(pp_q);
    sh       = ppx << {s2_q.chunk, 5'b0};
    acc_base = (s2_q.first && s2_q.chunk == 2'd0) ? '0 : acc_q;
    acc_d    = s2_q.neg ? acc_base - sh : acc_base + sh;
    wr_scr   = s2_q.valid && s2_q.last && (s2_q.chunk == 2'(NCHUNK - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= cmd_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_idx_i] <= wr_data_i;
    a_q  <= mem_q[cmd_i.a_idx];
    be_q <= mem_q[cmd_i.b_idx[3:0]];
    bs_q <= scr_q[cmd_i.b_idx];
    pp_q <= pp_d;
    if (s2_q.valid) acc_q <= acc_d;
    if (wr_scr) scr_q[s2_q.wr_idx] <= acc_d;
  end

  assign scr_rd_o = bs_q;
  assign det_o    = scr_q[DET_IDX];

endmodule

FILE: hdl/mi4_div.sv
// ----------------------------------------------------------------------------
// mi4_div
// Radix-2 restoring divider: one quotient bit a cycle, saturation and sign.
// ----------------------------------------------------------------------------
module mi4_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mi4_pkg::div_req_t                req_i,
  input  logic signed [mi4_pkg::ACC_W-1:0] num_i,
  input  logic signed [mi4_pkg::ACC_W-1:0] den_i,
  output logic                             valid_o,
  output mi4_pkg::out_item_t               result_o
);
  import mi4_pkg::*;

  logic [ACC_W-1:0]  nmag, dmag, den_q, r_q, r_d;
  logic [ACC_W:0]    r2;
  logic              ge;
  logic [ELEM_W-1:0] q_q, q_d;
  logic [4:0]        cnt_q;
  logic              run_q, valid_q, neg_q, big_q, sing_q, step_last;
  logic [3:0]        idx_q;
  out_item_t         res_d, res_q;

  always_comb begin
    nmag      = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
    dmag      = den_i[ACC_W-1] ? ACC_W'(-den_i) : ACC_W'(den_i);
    r2        = {r_q, 1'b0};
    ge        = (r2 >= {1'b0, den_q});
    r_d       = ge ? ACC_W'(r2 - {1'b0, den_q}) : r2[ACC_W-1:0];
    q_d       = {q_q[ELEM_W-2:0], ge};
    step_last = run_q && (cnt_q == 5'(ELEM_W - 1));
  end

  always_comb begin
    res_d.result_index = idx_q;
    res_d.singular     = sing_q;
    res_d.last_result  = &idx_q;
    res_d.saturated    = 1'b0;
    res_d.result_value = '0;
    if (!sing_q) begin
      if (!neg_q) begin
        if (big_q || q_d[ELEM_W-1]) begin
          res_d.result_value = Q_MAX;
          res_d.saturated    = 1'b1;
        end else begin
          res_d.result_value = q_d;
        end
      end else begin
        if (big_q || (q_d[ELEM_W-1] && q_d[ELEM_W-2:0] != '0)) begin
          res_d.result_value = Q_MIN;
          res_d.saturated    = 1'b1;
        end else begin
          res_d.result_value = -q_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= step_last;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (step_last) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q  <= dmag;
      r_q    <= nmag;
      q_q    <= '0;
      neg_q  <= num_i[ACC_W-1] ^ den_i[ACC_W-1];
      big_q  <= (nmag >= dmag);
      sing_q <= (den_i == '0);
      idx_q  <= req_i.idx;
    end else if (run_q) begin
      r_q <= r_d;
      q_q <= q_d;
      if (step_last) res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

FILE: hdl/matrix_inverse_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top: 4x4 Q16.16 inverse by adjugate over determinant
// Loads take one element per cycle while busy is low.
// Each result comes from the 32-step divider, started once the previous result is out.
// Async active-low reset idles the sequencer; element store is not cleared.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  mi4_pkg::in_item_t   item_i,
  output logic                busy,
  output logic                result_valid_o,
  output mi4_pkg::out_item_t  result_o
);
  import mi4_pkg::*;

  logic                     accept;
  mac_cmd_t                 cmd;
  div_req_t                 div_req;
  logic signed [ACC_W-1:0]  scr_rd, det;

  assign accept = start && !busy;

  mi4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .launch_i   (accept && item_i.last_element),
    .div_done_i (result_valid_o),
    .busy_o     (busy),
    .cmd_o      (cmd),
    .div_req_o  (div_req)
  );

  mi4_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_idx_i  (item_i.element_index),
    .wr_data_i (item_i.element_value),
    .cmd_i     (cmd),
    .scr_rd_o  (scr_rd),
    .det_o     (det)
  );

  mi4_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .num_i    (scr_rd),
    .den_i    (det),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

FILE: hdl/mi4_checker.sv
// ----------------------------------------------------------------------------
// mi4_checker
// Port-level checks of the 4x4 matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix_inverse_4x4_top_assert.svh"

module mi4_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input mi4_pkg::in_item_t   item_i,
  input logic                busy,
  input logic                result_valid_o,
  input mi4_pkg::out_item_t  result_o
);
  import mi4_pkg::*;

  `MI4_ASSERT(a_result_while_busy, result_valid_o |-> busy, "result beat outside busy")
  `MI4_ASSERT(a_idle_after_last, result_valid_o && result_o.last_result |=> !busy, "busy after last beat")
  `MI4_ASSERT(a_launch_busy, start && !busy && item_i.last_element |=> busy, "last element did not launch")
  `MI4_ASSERT(a_singular_zero, result_valid_o && result_o.singular |-> result_o.result_value == '0 && !result_o.saturated, "singular beat not zero")
  `MI4_ASSERT(a_sat_limit, result_valid_o && result_o.saturated |-> result_o.result_value == Q_MAX || result_o.result_value == Q_MIN, "saturated beat off limit")

endmodule

bind matrix_inverse_4x4_top mi4_checker u_checker (.*);

FILE: bench/tb_matrix_inverse_4x4_top.sv
// ----------------------------------------------------------------------------
// tb_matrix_inverse_4x4_top: self-checking bench for the 4x4 matrix inverse
// Loads matrices element by element, predicts each inverse from the exact
// integer adjugate and determinant, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_4x4_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mi4_pkg::*;

  typedef logic signed [159:0] wide_t;

  class inverse_scoreboard;
    logic [31:0] elems[16];
    out_item_t   inverse_q[$];
    int          errors;

    function wide_t at(int r, int c);
      logic [31:0] v;
      v = elems[(r * 4 + c) & 15];
      return {{128{v[31]}}, v};
    endfunction

    function wide_t minor3(int rw[3], int cl[3]);
      wide_t t0, t1, t2;
      t0 = at(rw[1], cl[1]) * at(rw[2], cl[2]) - at(rw[2], cl[1]) * at(rw[1], cl[2]);
      t1 = at(rw[1], cl[0]) * at(rw[2], cl[2]) - at(rw[2], cl[0]) * at(rw[1], cl[2]);
      t2 = at(rw[1], cl[0]) * at(rw[2], cl[1]) - at(rw[2], cl[0]) * at(rw[1], cl[1]);
      return at(rw[0], cl[0]) * t0 - at(rw[0], cl[1]) * t1 + at(rw[0], cl[2]) * t2;
    endfunction

    function wide_t cofactor(int i, int j);
      int    rw[3];
      int    cl[3];
      int    n;
      int    m;
      wide_t v;
      n = 0;
      m = 0;
      for (int k = 0; k < 4; k++) begin
        if (k != j) begin
          rw[n] = k;
          n++;
        end
        if (k != i) begin
          cl[m] = k;
          m++;
        end
      end
      v = minor3(rw, cl);
      return ((i + j) & 1) ? -v : v;
    endfunction

    function void note(in_item_t it);
      wide_t        adj[16];
      wide_t        det;
      logic [159:0] dmag;
      logic [159:0] num;
      logic [159:0] q;
      logic         neg;
      out_item_t    r;
      elems[it.element_index] = it.element_value;
      if (!it.last_element) return;
      for (int k = 0; k < 16; k++) adj[k] = cofactor(k >> 2, k & 3);
      det = '0;
      for (int k = 0; k < 4; k++) det = det + at(0, k) * adj[k * 4];
      dmag = det[159] ? -det : det;
      for (int k = 0; k < 16; k++) begin
        r = '0;
        r.result_index = 4'(k);
        r.last_result = (k == 15);
        if (det == 0) begin
          r.singular = 1'b1;
        end else begin
          num = adj[k][159] ? -adj[k] : adj[k];
          q = (num << 32) / dmag;
          neg = adj[k][159] != det[159];
          if (!neg) begin
            if (|q[159:32] || q[31:0] > Q_MAX) begin
              r.result_value = Q_MAX;
              r.saturated = 1'b1;
            end else r.result_value = q[31:0];
          end else begin
            if (|q[159:32] || q[31:0] > Q_MIN) begin
              r.result_value = Q_MIN;
              r.saturated = 1'b1;
            end else r.result_value = -q[31:0];
          end
        end
        inverse_q.push_back(r);
      end
    endfunction

    function void check(out_item_t got);
      out_item_t exp_r;
      if (inverse_q.size() == 0) begin
        $error("unexpected result beat index %0d", got.result_index);
        errors++;
        return;
      end
      exp_r = inverse_q.pop_front();
      if (got.result_index !== exp_r.result_index) begin
        $error("result_index exp %0d got %0d", exp_r.result_index, got.result_index);
        errors++;
      end
      if (got.result_value !== exp_r.result_value) begin
        $error("result_value exp %h got %h", exp_r.result_value, got.result_value);
        errors++;
      end
      if (got.singular !== exp_r.singular) begin
        $error("singular exp %0b got %0b", exp_r.singular, got.singular);
        errors++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated exp %0b got %0b", exp_r.saturated, got.saturated);
        errors++;
      end
      if (got.last_result !== exp_r.last_result) begin
        $error("last_result exp %0b got %0b", exp_r.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_item_t  item_i;
  logic      busy;
  logic      result_valid_o;
  out_item_t result_o;

  inverse_scoreboard sb;
  int  quiet_cycles;
  bit  calm;

  matrix_inverse_4x4_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .item_i(item_i),
    .busy(busy),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check(result_o);
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic load(logic [3:0] idx, logic [31:0] val, logic last);
    bit taken;
    while (!calm && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{element_index: idx, element_value: val, last_element: last};
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      if (taken) sb.note(item_i);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      2:       return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return 32'($signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
    endcase
  endfunction

  initial begin
    int order[16];
    int j;
    int t;
    int sent;
    sb = new();
    quiet_cycles = 0;
    calm = 0;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < 16; k++)
      load(4'(k), (k % 5 == 0) ? 32'h0001_0000 : 32'h0, k == 15);
    load(4'd0, 32'h0, 1'b1);
    load(4'd0, 32'h1, 1'b0);
    load(4'd5, 32'hFFFF_FFFF, 1'b0);
    load(4'd10, 32'h1, 1'b0);
    load(4'd15, 32'h1, 1'b1);
    load(4'd3, 32'h7FFF_FFFF, 1'b0);
    load(4'd12, 32'h8000_0000, 1'b1);

    sent = 0;
    while (sent < 360) begin
      calm = (sent >= 100 && sent < 180);
      if ($urandom_range(9) < 8) begin
        for (int k = 0; k < 16; k++) order[k] = k;
        for (int k = 15; k > 0; k--) begin
          j = $urandom_range(k);
          t = order[k];
          order[k] = order[j];
          order[j] = t;
        end
        for (int k = 0; k < 16; k++) load(4'(order[k]), pick_value(), k == 15);
        sent += 16;
      end else begin
        load(4'($urandom_range(15)), pick_value(), $urandom_range(7) == 0);
        sent++;
      end
    end
    start <= 1'b0;

    while (sb.inverse_q.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (sb.errors == 0 && sb.inverse_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/mi4_pkg.sv
hdl/mi4_ctrl.sv
hdl/mi4_mac.sv
hdl/mi4_div.sv
hdl/matrix_inverse_4x4_top.sv
hdl/mi4_checker.sv
bench/tb_matrix_inverse_4x4_top.sv
